@@ src/running_median_two_heaps_top_defines.svh @@
// Assertion macros for the running median block
`ifndef RUNNING_MEDIAN_TWO_HEAPS_TOP_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_TOP_DEFINES_SVH
// assert that a condition implies a consequence in the same cycle
`define RM_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("rm check failed");
// assert that a condition implies a consequence in the next cycle
`define RM_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("rm check failed");
`endif

@@ src/rm_pkg.sv @@
// ----------------------------------------------------------------------------
// rm_pkg
// Types and defaults shared by the running median block.
// ----------------------------------------------------------------------------
package rm_pkg;
   localparam int HalfDepthDefault   = 512;
   localparam int SampleWidthDefault = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_RD,
      ST_PUSH_CMP,
      ST_TOPS,
      ST_TOPS_WAIT,
      ST_POP_INIT,
      ST_POP_RD,
      ST_POP_CMP,
      ST_POP_WR,
      ST_DONE
   } state_type;
endpackage

@@ src/running_median_two_heaps_top.sv @@
// ----------------------------------------------------------------------------
// running_median_two_heaps_top
// Running lower median of a signed sample stream using two binary heaps.
// ----------------------------------------------------------------------------
// Raise start with a sample while busy is low. Busy rises for the whole
// update, and rsp_valid marks the one cycle carrying the median and the drop
// flag, which the receiver must take as it comes. A dropped item goes
// straight to reading the two tops. Otherwise the insert walks the heap one
// level at a time, a parent read and then a compare, over the registered-read
// heap memory, then the two tops are read. When the tops cross, two pops and
// two inserts follow. The result strobe comes in the first cycle with busy
// low, and a new item may be started in that same cycle. Heap memories need
// no clearing.
module running_median_two_heaps_top
   import rm_pkg::*;
#(
   parameter int HALF_DEPTH   = HalfDepthDefault,
   parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                           rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_median,
   output logic                           rsp_full_drop
);
   localparam int AW = $clog2(HALF_DEPTH + 1);  // 1-based index width
   localparam int CW = $clog2(HALF_DEPTH + 1);
   localparam int W  = SAMPLE_WIDTH;
   localparam logic [CW-1:0] FullCount = CW'(HALF_DEPTH);

   // heap memories, 1-based, index 0 unused; heap select 0 lower, 1 upper
   logic [W-1:0] mem_lo [HALF_DEPTH+1];
   logic [W-1:0] mem_up [HALF_DEPTH+1];

   state_type state_ff, state_in;
   logic [CW-1:0] lcnt_ff, lcnt_in, ucnt_ff, ucnt_in;
   logic          nup_ff, nup_in;
   logic          hsel_ff, hsel_in;     // heap being worked on
   logic [AW-1:0] idx_ff, idx_in;       // hole index
   logic [AW-1:0] ch_ff, ch_in;         // chosen child in pop
   logic [W-1:0]  val_ff, val_in;       // value being placed (biased)
   logic [W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [W-1:0]  c1_ff, c1_in;         // first child during pop
   logic [1:0]    phase_ff, phase_in;   // swap sequence step
   logic          drop_ff, drop_in;
   logic [W-1:0]  med_ff, med_in;
   logic          rv_ff, rv_in;

   // memory port
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [W-1:0]  wdata, rd_lo_ff, rd_up_ff, rd;
   logic [CW-1:0] cnt_sel;
   logic          hi;                   // shared comparator: x above y
   logic [W-1:0]  cx, cy;
   logic [W-1:0]  pick_val;             // of the two children, the one that sits above
   logic [AW-1:0] pick_idx;

   always_ff @(posedge clock) begin
      if (we && !hsel_ff) mem_lo[waddr] <= wdata;
      if (we &&  hsel_ff) mem_up[waddr] <= wdata;
      rd_lo_ff <= mem_lo[raddr];
      rd_up_ff <= mem_up[raddr];
   end
   assign rd = hsel_ff ? rd_up_ff : rd_lo_ff;
   assign cnt_sel = hsel_ff ? ucnt_ff : lcnt_ff;
   assign hi = hsel_ff ? (cx < cy) : (cx > cy);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lcnt_ff  <= '0;
         ucnt_ff  <= '0;
         nup_ff   <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         lcnt_ff  <= lcnt_in;
         ucnt_ff  <= ucnt_in;
         nup_ff   <= nup_in;
         rv_ff    <= rv_in;
      end
      hsel_ff  <= hsel_in;
      idx_ff   <= idx_in;
      ch_ff    <= ch_in;
      val_ff   <= val_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c1_ff    <= c1_in;
      phase_ff <= phase_in;
      drop_ff  <= drop_in;
      med_ff   <= med_in;
   end

   always_comb begin
      state_in = state_ff;
      lcnt_in  = lcnt_ff;
      ucnt_in  = ucnt_ff;
      nup_in   = nup_ff;
      hsel_in  = hsel_ff;
      idx_in   = idx_ff;
      ch_in    = ch_ff;
      val_in   = val_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c1_in    = c1_ff;
      phase_in = phase_ff;
      drop_in  = drop_ff;
      med_in   = med_ff;
      rv_in    = 1'b0;
      we       = 1'b0;
      waddr    = idx_ff;
      wdata    = val_ff;
      raddr    = idx_ff >> 1;
      cx       = val_ff;
      cy       = rd;
      pick_val = c1_ff;
      pick_idx = ch_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               val_in   = W'(req_sample) ^ {1'b1, {(W-1){1'b0}}};
               hsel_in  = nup_ff;
               phase_in = 2'd0;
               drop_in  = 1'b0;
               if ((nup_ff ? ucnt_ff : lcnt_ff) == FullCount) begin
                  drop_in  = 1'b1;
                  state_in = ST_TOPS;
               end else begin
                  if (nup_ff) begin
                     ucnt_in = ucnt_ff + 1'b1;
                     idx_in  = AW'(ucnt_ff) + 1'b1;
                  end else begin
                     lcnt_in = lcnt_ff + 1'b1;
                     idx_in  = AW'(lcnt_ff) + 1'b1;
                  end
                  nup_in   = !nup_ff;
                  state_in = ST_PUSH_RD;
               end
            end
         end
         // sift up: read parent of hole
         ST_PUSH_RD: begin
            raddr = idx_ff >> 1;
            if (idx_ff == AW'(1)) begin
               we       = 1'b1;
               state_in = ST_TOPS;
            end else begin
               state_in = ST_PUSH_CMP;
            end
         end
         ST_PUSH_CMP: begin
            cx = val_ff;
            cy = rd;
            if (hi) begin
               we       = 1'b1;
               wdata    = rd;
               idx_in   = idx_ff >> 1;
               state_in = ST_PUSH_RD;
            end else begin
               we       = 1'b1;
               state_in = ST_TOPS;
            end
         end
         // read both tops, or continue the swap sequence
         ST_TOPS: begin
            raddr = AW'(1);
            if (phase_ff == 2'd0) begin
               state_in = ST_TOPS_WAIT;
            end else if (phase_ff == 2'd1) begin
               // pop upper next
               hsel_in  = 1'b1;
               state_in = ST_POP_INIT;
            end else if (phase_ff == 2'd2) begin
               // push b onto lower
               hsel_in  = 1'b0;
               val_in   = b_ff;
               lcnt_in  = lcnt_ff + 1'b1;
               idx_in   = AW'(lcnt_ff) + 1'b1;
               phase_in = 2'd3;
               state_in = ST_PUSH_RD;
            end else if (!hsel_ff) begin
               // push a onto upper
               hsel_in  = 1'b1;
               val_in   = a_ff;
               ucnt_in  = ucnt_ff + 1'b1;
               idx_in   = AW'(ucnt_ff) + 1'b1;
               state_in = ST_PUSH_RD;
            end else begin
               // swap finished: read the new tops, no further swap check
               state_in = ST_TOPS_WAIT;
            end
         end
         ST_TOPS_WAIT: begin
            raddr = AW'(1);
            med_in = (lcnt_ff != '0) ? (rd_lo_ff ^ {1'b1, {(W-1){1'b0}}}) : '0;
            if (!drop_ff && lcnt_ff != '0 && ucnt_ff != '0 && rd_lo_ff > rd_up_ff
                && phase_ff == 2'd0) begin
               a_in     = rd_lo_ff;
               b_in     = rd_up_ff;
               hsel_in  = 1'b0;
               phase_in = 2'd1;
               state_in = ST_POP_INIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         // pop: read last entry
         ST_POP_INIT: begin
            raddr    = AW'(cnt_sel);
            idx_in   = AW'(1);
            if (hsel_ff) ucnt_in = ucnt_ff - 1'b1;
            else         lcnt_in = lcnt_ff - 1'b1;
            state_in = ST_POP_RD;
            ch_in    = '0;
         end
         // sift down; ch_ff==0 means last value pending capture
         ST_POP_RD: begin
            if (ch_ff == '0) val_in = rd;
            raddr = AW'({idx_ff, 1'b0});
            if ({1'b0, idx_ff, 1'b0} > {2'b0, cnt_sel}) begin
               state_in = ST_POP_WR;
            end else begin
               ch_in    = AW'({idx_ff, 1'b0});
               state_in = ST_POP_CMP;
            end
         end
         ST_POP_CMP: begin
            // an even ch_ff captures the left child, an odd one compares the right
            if (ch_ff[0] == 1'b0) begin
               c1_in = rd;
               raddr = ch_ff + 1'b1;
               if ({1'b0, ch_ff} < {1'b0, AW'(cnt_sel)}) begin
                  ch_in    = ch_ff + 1'b1;  // odd marks right read
               end else begin
                  // only left child
                  cx = rd;
                  cy = val_ff;
                  if (hi) begin
                     we     = 1'b1;
                     waddr  = idx_ff;
                     wdata  = rd;
                     idx_in = ch_ff;
                     state_in = ST_POP_RD;
                  end else begin
                     state_in = ST_POP_WR;
                  end
               end
            end else begin
               // choose between left c1_ff and right rd
               cx       = rd;
               cy       = c1_ff;
               pick_val = hi ? rd : c1_ff;
               pick_idx = hi ? ch_ff : ch_ff - 1'b1;
               // move the chosen child up when it beats the last value
               if (hsel_ff ? (pick_val < val_ff) : (pick_val > val_ff)) begin
                  we       = 1'b1;
                  waddr    = idx_ff;
                  wdata    = pick_val;
                  idx_in   = pick_idx;
                  state_in = ST_POP_RD;
               end else begin
                  state_in = ST_POP_WR;
               end
            end
         end
         ST_POP_WR: begin
            we    = 1'b1;
            waddr = idx_ff;
            wdata = val_ff;
            state_in = ST_TOPS;
            phase_in = (phase_ff == 2'd1 && hsel_ff) ? 2'd2 : phase_ff;
         end
         ST_DONE: begin
            rv_in    = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rv_ff;
   assign rsp_median    = med_ff;
   assign rsp_full_drop = drop_ff;
endmodule

@@ src/rm_checker.sv @@
// ----------------------------------------------------------------------------
// rm_checker
// Port-level checks for the running median block.
// ----------------------------------------------------------------------------
`include "running_median_two_heaps_top_defines.svh"
module rm_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   `RM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `RM_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `RM_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
endmodule

bind running_median_two_heaps_top rm_checker u_rm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid)
);

@@ bench/running_median_two_heaps_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_two_heaps_top_tb
// Drives signed samples through the start/busy handshake. A two-heap
// predictor in the bench works out the lower median and the drop flag of
// each item. Every strobed result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module running_median_two_heaps_top_tb
   import rm_pkg::*;
();

   localparam int HALF_DEPTH   = HalfDepthDefault;
   localparam int SAMPLE_WIDTH = SampleWidthDefault;
   localparam int HeapLower    = 0;
   localparam int HeapUpper    = 1;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef struct packed {
      sample_type median;
      logic       full_drop;
   } median_result_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   sample_type req_sample;
   logic       rsp_valid;
   sample_type rsp_median;
   logic       rsp_full_drop;

   running_median_two_heaps_top #(
      .HALF_DEPTH  (HALF_DEPTH),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_median   (rsp_median),
      .rsp_full_drop(rsp_full_drop)
   );

   // predictor state: index 0 is the lower max-heap, 1 the upper min-heap
   sample_type        heap_mem[2][1:HALF_DEPTH];
   int                heap_count[2];
   bit                next_to_upper;
   median_result_type pending_medians[$];
   int                error_count;
   int                samples_sent;
   int                drops_seen;
   int                results_checked;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit sits_above(int h, sample_type a, sample_type b);
      return (h == HeapLower) ? (a > b) : (a < b);
   endfunction

   function automatic void heap_insert(int h, sample_type v);
      int i;
      heap_count[h]++;
      i = heap_count[h];
      while (i != 1 && sits_above(h, v, heap_mem[h][i/2])) begin
         heap_mem[h][i] = heap_mem[h][i/2];
         i = i / 2;
      end
      heap_mem[h][i] = v;
   endfunction

   function automatic void heap_remove_top(int h);
      int         n;
      int         parent;
      int         child;
      sample_type last;
      if (heap_count[h] == 0) return;
      last   = heap_mem[h][heap_count[h]];
      n      = heap_count[h] - 1;
      heap_count[h] = n;
      parent = 1;
      child  = 2;
      while (child <= n) begin
         if (child < n && sits_above(h, heap_mem[h][child+1], heap_mem[h][child]))
            child++;
         if (!sits_above(h, heap_mem[h][child], last)) break;
         heap_mem[h][parent] = heap_mem[h][child];
         parent = child;
         child  = child * 2;
      end
      heap_mem[h][parent] = last;
   endfunction

   function automatic median_result_type predict_median(sample_type v);
      median_result_type r;
      int                h;
      sample_type        lo_top;
      sample_type        up_top;
      h = next_to_upper ? HeapUpper : HeapLower;
      r.full_drop = (heap_count[h] >= HALF_DEPTH);
      if (!r.full_drop) begin
         heap_insert(h, v);
         next_to_upper = !next_to_upper;
         if (heap_count[HeapLower] > 0 && heap_count[HeapUpper] > 0 &&
             heap_mem[HeapLower][1] > heap_mem[HeapUpper][1]) begin
            lo_top = heap_mem[HeapLower][1];
            up_top = heap_mem[HeapUpper][1];
            heap_remove_top(HeapLower);
            heap_remove_top(HeapUpper);
            heap_insert(HeapLower, up_top);
            heap_insert(HeapUpper, lo_top);
         end
      end
      r.median = (heap_count[HeapLower] > 0) ? heap_mem[HeapLower][1] : '0;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      $display("ERROR %0t: %s", $realtime, what);
   endtask

   // hold start high until the item is taken, then idle for a random gap
   task automatic send_sample(sample_type v);
      int gap;
      start      <= 1'b1;
      req_sample <= v;
      do @(posedge clock); while (busy);
      pending_medians.push_back(predict_median(v));
      samples_sent++;
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) :
            (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3));
      if ($urandom_range(0, 99) < 30) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(0, 4))
         0:       return sample_type'($urandom);
         1:       return sample_type'(int'($urandom_range(0, 15)) - 8);
         2:       return $urandom_range(0, 1) ?
                         sample_type'(32767 - int'($urandom_range(0, 3))) :
                         sample_type'(-32768 + int'($urandom_range(0, 3)));
         3:       return sample_type'(int'($urandom_range(0, 400)) - 200);
         default: return sample_type'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      median_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_medians.size() == 0) begin
            report_mismatch($sformatf("unexpected result median=%0d drop=%0b",
                                      rsp_median, rsp_full_drop));
         end else begin
            exp_r = pending_medians.pop_front();
            results_checked++;
            if (rsp_full_drop) drops_seen++;
            if (rsp_median !== exp_r.median)
               report_mismatch($sformatf("median %0d, expected %0d",
                                         rsp_median, exp_r.median));
            if (rsp_full_drop !== exp_r.full_drop)
               report_mismatch($sformatf("full_drop %0b, expected %0b",
                                         rsp_full_drop, exp_r.full_drop));
         end
      end
   end

   task automatic test_extremes();
      sample_type vals[$] = '{16'sh8000, 16'sh7fff, 0, -1, 1, 16'sh7fff,
                              16'sh8000, 16'sh5555, 16'shaaaa, 0};
      foreach (vals[k]) send_sample(vals[k]);
   endtask

   task automatic test_equal_tops();
      repeat (6) send_sample(16'sd42);
      send_sample(16'sd41);
      send_sample(16'sd43);
      send_sample(16'sd42);
   endtask

   task automatic test_drained_restart();
      // let every pending item finish before new ones are offered
      start <= 1'b0;
      wait (pending_medians.size() == 0);
      @(posedge clock);
      repeat (4) send_sample(random_sample());
   endtask

   task automatic test_random_fill();
      while (heap_count[HeapLower] < HALF_DEPTH || heap_count[HeapUpper] < HALF_DEPTH)
         send_sample(random_sample());
   endtask

   task automatic test_full_drop();
      repeat (700) send_sample(random_sample());
   endtask

   initial begin
      error_count     = 0;
      samples_sent    = 0;
      drops_seen      = 0;
      results_checked = 0;
      heap_count[0]   = 0;
      heap_count[1]   = 0;
      next_to_upper   = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_sample = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_equal_tops();
      test_drained_restart();
      test_random_fill();
      test_full_drop();
      start <= 1'b0;
      fork
         wait (pending_medians.size() == 0);
         repeat (2000) @(posedge clock);
      join_any
      disable fork;
      repeat (200) @(posedge clock);
      if (pending_medians.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_medians.size()));
      $display("Sent %0d samples, checked %0d medians, %0d with a full heap drop.",
               samples_sent, results_checked, drops_seen);
      $display("Covered extremes, equal tops, back-to-back and gapped items, full heaps.");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout");
      $display("Test completed with failures");
      $finish;
   end
endmodule
